// ----- hdl/tbeq_pkg.sv -----
// Shared types and constants for the ten-band biquad cascade equalizer.
// No dependencies; imported by every module of the block.
package tbeq_pkg;

  localparam int DATA_W          = 32;   // coefficient and signal word
  localparam int SCALE_W         = 16;   // headroom prescale, unsigned Q1.15
  localparam int SCALE_FRAC      = 15;
  localparam int BAND_IDX_W      = 4;
  localparam int SLOT_W          = 3;
  localparam int NSLOT           = 5;    // b0 b1 b2 a1 a2
  localparam int NDLY            = 4;    // x1 x2 y1 y2
  localparam int DEF_BANDS       = 10;
  localparam int DEF_FRAC_BITS   = 27;
  localparam int DEF_SAMPLE_W    = 16;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd32768;

  typedef enum logic [0:0] {
    OP_SAMPLE   = 1'b0,
    OP_COEF_WR  = 1'b1
  } opcode_t;

  localparam logic [SLOT_W-1:0] SLOT_B0 = 3'd0;
  localparam logic [SLOT_W-1:0] SLOT_B1 = 3'd1;
  localparam logic [SLOT_W-1:0] SLOT_B2 = 3'd2;
  localparam logic [SLOT_W-1:0] SLOT_A1 = 3'd3;
  localparam logic [SLOT_W-1:0] SLOT_A2 = 3'd4;

  // control word for the shared multiply-accumulate unit
  typedef struct packed {
    logic valid;
    logic clear;   // start a new sum with this product
    logic sub;     // subtract the product
  } mac_ctl_t;

endpackage

// ----- hdl/tbeq_div.sv -----
// Divider by the constant full-scale value 2^(SAMPLE_WIDTH-1)-1, by folding:
// n = hi*2^K + lo = hi*(2^K-1) + (hi+lo). Depends on tbeq_pkg.
module tbeq_div
  import tbeq_pkg::*;
#(
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_W,
  parameter int NW           = 45
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  output logic [NW-1:0] quot,
  output logic          done
);

  localparam int K = SAMPLE_WIDTH - 1;
  localparam logic [NW-1:0] FS = NW'((1 << K) - 1);

  logic [NW-1:0] rest;
  logic [NW-1:0] q_acc;
  logic [NW-1:0] hi;
  logic [NW-1:0] lo;
  logic          busy;

  assign hi   = rest >> K;
  assign lo   = NW'(rest[K-1:0]);
  assign quot = q_acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && !start && (hi == '0);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && hi == '0) begin
        busy <= 1'b0;
      end
    end
  end

  // one fold per cycle until the rest is below 2^K; rest equal to FS adds one
  always_ff @(posedge clk) begin
    if (start) begin
      rest  <= num;
      q_acc <= '0;
    end else if (busy) begin
      if (hi != '0) begin
        q_acc <= q_acc + hi;
        rest  <= hi + lo;
      end else if (rest == FS) begin
        q_acc <= q_acc + NW'(1);
      end
    end
  end

endmodule

// ----- hdl/tbeq_mac.sv -----
// Shared multiply-accumulate unit: registered 32x32 product, wide accumulator,
// round half up at the binary point and saturate to 32 bits. Depends on tbeq_pkg.
module tbeq_mac
  import tbeq_pkg::*;
#(
  parameter int COEF_FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  mac_ctl_t                 ctl,
  input  logic signed [DATA_W-1:0] coef,
  input  logic signed [DATA_W-1:0] data,
  output logic signed [DATA_W-1:0] result
);

  localparam int PW = 2 * DATA_W;
  localparam int AW = PW + 3;
  localparam logic signed [AW-1:0] HALF = AW'(1) <<< (COEF_FRAC_BITS - 1);
  localparam logic signed [AW-1:0] SMAX = AW'(32'sh7fffffff);
  localparam logic signed [AW-1:0] SMIN = -AW'(32'sh7fffffff) - AW'(1);

  mac_ctl_t                 ctl_q;
  logic signed [PW-1:0]     prod;
  logic signed [AW-1:0]     acc;
  logic signed [AW-1:0]     prod_x;
  logic signed [AW-1:0]     rnd;

  assign prod_x = AW'(prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl;
    end
  end

  always_ff @(posedge clk) begin
    prod <= coef * data;
    if (ctl_q.valid) begin
      if (ctl_q.clear) begin
        acc <= ctl_q.sub ? -prod_x : prod_x;
      end else begin
        acc <= ctl_q.sub ? acc - prod_x : acc + prod_x;
      end
    end
  end

  always_comb begin
    rnd = (acc + HALF) >>> COEF_FRAC_BITS;
    if (rnd > SMAX) begin
      result = 32'sh7fffffff;
    end else if (rnd < SMIN) begin
      result = 32'sh80000000;
    end else begin
      result = rnd[DATA_W-1:0];
    end
  end

endmodule

// ----- hdl/ten_band_biquad_cascade_equalizer.sv -----
// Ten-band cascaded biquad equalizer: one sample at a time, one shared MAC.
// Depends on tbeq_pkg, tbeq_div and tbeq_mac.
//
// An accepted sample item is worked through in order: the numerator is
// formed, then divided by full scale (at most four folding steps at the
// defaults), then each band runs on the single multiply-accumulate unit
// (coefficient and delay read, five products, then the pipeline drains,
// with the delay write-back in its last step), then the output is scaled
// and loaded into the output register. in_ready returns with out_valid,
// and a result not yet taken holds the block in its last step. A
// coefficient write is taken while idle and gives no result. A result
// waits in the output register while the next item is accepted.
// Coefficients and delay lines come out of reset as pass-through and zero.
module ten_band_biquad_cascade_equalizer
  import tbeq_pkg::*;
#(
  parameter int BANDS          = DEF_BANDS,
  parameter int COEF_FRAC_BITS = DEF_FRAC_BITS,
  parameter int SAMPLE_WIDTH   = DEF_SAMPLE_W
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [SCALE_W-1:0]             cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           opcode,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
  input  logic [BAND_IDX_W-1:0]          band_index,
  input  logic [SLOT_W-1:0]              coef_slot,
  input  logic signed [DATA_W-1:0]       coef_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] sample_out
);

  localparam int NCOEF = BANDS * NSLOT;
  localparam int CAW   = $clog2(NCOEF);
  localparam int BW    = (BANDS > 1) ? $clog2(BANDS) : 1;
  localparam int MW    = SAMPLE_WIDTH + SCALE_W;
  localparam int NW    = MW + COEF_FRAC_BITS - SCALE_FRAC + 1;
  localparam int QE    = ((NW > DATA_W) ? NW : DATA_W) + 1;
  localparam int PRW   = SAMPLE_WIDTH + SCALE_W + 1;
  localparam int ROW_W = NDLY * DATA_W;
  localparam logic [NW-1:0] FS_HALF = NW'(((1 << (SAMPLE_WIDTH - 1)) - 1) / 2);
  localparam logic signed [DATA_W-1:0] FS_W = DATA_W'((1 << (SAMPLE_WIDTH - 1)) - 1);
  localparam logic signed [DATA_W-1:0] ONE  = DATA_W'(1) <<< COEF_FRAC_BITS;
  localparam logic signed [QE-1:0] SMAX = QE'(32'sh7fffffff);
  localparam logic signed [QE-1:0] SMIN = -QE'(32'sh7fffffff) - QE'(1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_PRE  = 6'b000010,
    S_DIV  = 6'b000100,
    S_BAND = 6'b001000,
    S_OUT  = 6'b010000,
    S_EMIT = 6'b100000
  } state_t;

  state_t state;
  logic [2:0]               phase;
  logic [BW-1:0]            band;
  logic [CAW-1:0]           coef_base;
  logic [SCALE_W-1:0]       headroom_scale;
  logic signed [SAMPLE_WIDTH-1:0] sample_reg;
  logic                     neg;
  logic signed [DATA_W-1:0] x;

  // coefficient store with per-entry valid bits (invalid reads as pass-through)
  logic [DATA_W-1:0]        coef_mem [NCOEF];
  logic [NCOEF-1:0]         coef_vld;
  logic [DATA_W-1:0]        coef_rd;
  logic                     coef_rd_vld;
  logic                     coef_rd_b0;
  logic [CAW-1:0]           coef_raddr;
  logic [8:0]               coef_waddr;
  logic                     coef_we;

  // delay store, one row of {y2, y1, x2, x1} per band
  logic [ROW_W-1:0]         dly_mem [BANDS];
  logic [BANDS-1:0]         dly_vld;
  logic [ROW_W-1:0]         dly_rd;
  logic                     dly_rd_vld;
  logic [ROW_W-1:0]         row;

  logic                     accept;
  logic signed [PRW-1:0]    prod_s;
  logic [PRW-1:0]           mag_full;
  logic [NW-1:0]            num;
  logic [NW-1:0]            quot;
  logic                     div_done;
  logic signed [QE-1:0]     q_signed;
  logic signed [DATA_W-1:0] x_norm;

  mac_ctl_t                 mac_ctl;
  logic signed [DATA_W-1:0] mac_coef;
  logic signed [DATA_W-1:0] mac_data;
  logic signed [DATA_W-1:0] mac_y;
  logic signed [DATA_W-1:0] coef_eff;
  logic signed [DATA_W-1:0] x_clip;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  assign coef_waddr = ({5'd0, band_index} << 2) + {5'd0, band_index} + {6'd0, coef_slot};
  assign coef_we    = accept && (opcode == OP_COEF_WR)
                      && ({1'b0, band_index} < 5'(BANDS)) && (coef_slot < SLOT_W'(NSLOT));
  assign coef_raddr = coef_base + CAW'(phase);

  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[coef_waddr[CAW-1:0]] <= coef_value;
    end
    if (state == S_BAND && phase < 3'(NSLOT)) begin
      coef_rd    <= coef_mem[coef_raddr];
      coef_rd_b0 <= (phase == 3'(SLOT_B0));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_vld    <= '0;
      coef_rd_vld <= 1'b0;
    end else begin
      if (coef_we) begin
        coef_vld[coef_waddr[CAW-1:0]] <= 1'b1;
      end
      if (state == S_BAND && phase < 3'(NSLOT)) begin
        coef_rd_vld <= coef_vld[coef_raddr];
      end
    end
  end

  assign coef_eff = coef_rd_vld ? coef_rd : (coef_rd_b0 ? ONE : '0);
  assign row      = dly_rd_vld ? dly_rd : '0;

  always_ff @(posedge clk) begin
    if (state == S_BAND && phase == 3'd0) begin
      dly_rd <= dly_mem[band];
    end
    if (state == S_BAND && phase == 3'd7) begin
      dly_mem[band] <= {row[2*DATA_W +: DATA_W], mac_y, row[0 +: DATA_W], x};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dly_vld    <= '0;
      dly_rd_vld <= 1'b0;
    end else begin
      if (state == S_BAND && phase == 3'd0) begin
        dly_rd_vld <= dly_vld[band];
      end
      if (state == S_BAND && phase == 3'd7) begin
        dly_vld[band] <= 1'b1;
      end
    end
  end

  // normalize: |sample * scale| << (F-15), plus half of full scale, then / FS
  assign prod_s   = $signed(sample_reg) * $signed({1'b0, headroom_scale});
  assign mag_full = prod_s[PRW-1] ? PRW'(-prod_s) : PRW'(prod_s);
  assign num      = (NW'(mag_full[MW-1:0]) << (COEF_FRAC_BITS - SCALE_FRAC)) + FS_HALF;

  tbeq_div #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .NW           (NW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_PRE),
    .num   (num),
    .quot  (quot),
    .done  (div_done)
  );

  always_comb begin
    q_signed = neg ? -$signed(QE'(quot)) : $signed(QE'(quot));
    if (q_signed > SMAX) begin
      x_norm = 32'sh7fffffff;
    end else if (q_signed < SMIN) begin
      x_norm = 32'sh80000000;
    end else begin
      x_norm = q_signed[DATA_W-1:0];
    end
  end

  always_comb begin
    if (x > ONE) begin
      x_clip = ONE;
    end else if (x < -ONE) begin
      x_clip = -ONE;
    end else begin
      x_clip = x;
    end
  end

  // operand select for the shared MAC
  always_comb begin
    mac_ctl  = '0;
    mac_coef = coef_eff;
    mac_data = x;
    if (state == S_BAND) begin
      unique case (phase)
        3'd1: begin
          mac_ctl  = '{valid: 1'b1, clear: 1'b1, sub: 1'b0};
          mac_data = x;
        end
        3'd2: begin
          mac_ctl  = '{valid: 1'b1, clear: 1'b0, sub: 1'b0};
          mac_data = row[0 +: DATA_W];
        end
        3'd3: begin
          mac_ctl  = '{valid: 1'b1, clear: 1'b0, sub: 1'b0};
          mac_data = row[DATA_W +: DATA_W];
        end
        3'd4: begin
          mac_ctl  = '{valid: 1'b1, clear: 1'b0, sub: 1'b1};
          mac_data = row[2*DATA_W +: DATA_W];
        end
        3'd5: begin
          mac_ctl  = '{valid: 1'b1, clear: 1'b0, sub: 1'b1};
          mac_data = row[3*DATA_W +: DATA_W];
        end
        default: begin
          mac_ctl = '0;
        end
      endcase
    end else if (state == S_OUT && phase == 3'd0) begin
      mac_ctl  = '{valid: 1'b1, clear: 1'b1, sub: 1'b0};
      mac_coef = FS_W;
      mac_data = x_clip;
    end
  end

  tbeq_mac #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctl    (mac_ctl),
    .coef   (mac_coef),
    .data   (mac_data),
    .result (mac_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      headroom_scale <= SCALE_RESET;
    end else if (cfg_write) begin
      headroom_scale <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_reg <= sample_in;
    end
    if (state == S_PRE) begin
      neg <= prod_s[PRW-1];
    end
    if (state == S_DIV && div_done) begin
      x <= x_norm;
    end else if (state == S_BAND && phase == 3'd7) begin
      x <= mac_y;
    end
    if (state == S_EMIT && (!out_valid || out_ready)) begin
      sample_out <= mac_y[SAMPLE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= '0;
      band      <= '0;
      coef_base <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_EMIT && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept && opcode == OP_SAMPLE) begin
            state <= S_PRE;
          end
        end
        S_PRE: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            state     <= S_BAND;
            phase     <= '0;
            band      <= '0;
            coef_base <= '0;
          end
        end
        S_BAND: begin
          phase <= phase + 1'b1;
          if (phase == 3'd7) begin
            if (band == BW'(BANDS - 1)) begin
              state <= S_OUT;
            end else begin
              band      <= band + 1'b1;
              coef_base <= coef_base + CAW'(NSLOT);
            end
          end
        end
        S_OUT: begin
          // product registers, then accumulates; the result is ready in S_EMIT
          phase <= phase + 1'b1;
          if (phase == 3'd1) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
